/* design/jse_pkg.sv */
// Shared types and constants of the JSON string escaper.
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

    // One input transaction: a string byte plus framing flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_string;
        logic       last_of_string;
        logic       empty_string;
    } t_in;

    // One output transaction: a byte of the escaped literal.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       closing_quote;
    } t_out;

    // Body kinds of a command.
    localparam logic [1:0] K_NONE = 2'd0;  // no body bytes
    localparam logic [1:0] K_LIT  = 2'd1;  // raw bytes, count in nbytes + 1
    localparam logic [1:0] K_ESC  = 2'd2;  // backslash and one character
    localparam logic [1:0] K_HEX  = 2'd3;  // \u00XX of bytes[0]

    // Output phases of a command, in emission order.
    localparam logic [1:0] P_OPEN  = 2'd0;
    localparam logic [1:0] P_REPL  = 2'd1;
    localparam logic [1:0] P_BODY  = 2'd2;
    localparam logic [1:0] P_CLOSE = 2'd3;

    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;

    // Command from the classifier to the emitter: opening quote, a run of
    // replacement characters, a body, and the closing quote.
    typedef struct packed {
        logic            open;
        logic [2:0]      repl;
        logic [1:0]      kind;
        logic [1:0]      nbytes;
        logic [3:0][7:0] bytes;
        logic            close;
    } t_cmd;

    // Queue status seen by the top level and the emitter.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

/* design/jse_front.sv */
// Classifier: tracks the pending UTF-8 sequence and turns each item into a command when it has output.
`timescale 1ns / 1ps
`default_nettype none

module jse_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  jse_pkg::t_in      i_item,
    output logic              o_push,
    output jse_pkg::t_cmd     o_cmd
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [7:0] r_pend [3];
    logic [7:0] n_pend [3];

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] len;
        len = 3'd0;
        if (lead >= 8'hC2 && lead <= 8'hDF) len = 3'd2;
        else if (lead >= 8'hE0 && lead <= 8'hEF) len = 3'd3;
        else if (lead >= 8'hF0 && lead <= 8'hF4) len = 3'd4;
        return len;
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic ok;
        ok = ((b & 8'hC0) == 8'h80);
        if (pos == 2'd1) begin
            if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
            if (lead == 8'hED && b > 8'h9F) ok = 1'b0;
            if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
            if (lead == 8'hF4 && b > 8'h8F) ok = 1'b0;
        end
        return ok;
    endfunction

    always_comb begin
        logic [1:0] cnt0;
        logic [7:0] b;
        logic [7:0] esc;
        logic [2:0] len;
        logic       do_fresh;

        b        = i_item.data_byte;
        cnt0     = i_item.first_of_string ? 2'd0 : r_cnt;
        n_cnt    = cnt0;
        n_pend   = r_pend;
        do_fresh = 1'b0;
        esc      = 8'h00;
        len      = seq_len(r_pend[0]);

        o_cmd        = '0;
        o_cmd.open   = i_item.first_of_string;
        o_cmd.close  = i_item.last_of_string;
        o_cmd.kind   = jse_pkg::K_NONE;

        if (!i_item.empty_string) begin
            if (cnt0 == 2'd0) begin
                do_fresh = 1'b1;
            end else if (len != 3'd0 && {1'b0, cnt0} < len && cont_ok(r_pend[0], cnt0, b)) begin
                if ({1'b0, cnt0} + 3'd1 == len) begin
                    // Sequence complete: release held bytes and this one.
                    o_cmd.kind   = jse_pkg::K_LIT;
                    o_cmd.nbytes = cnt0;
                    for (int i = 0; i < 3; i++) begin
                        o_cmd.bytes[i] = r_pend[i];
                    end
                    o_cmd.bytes[cnt0] = b;
                    n_cnt = 2'd0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (i[1:0] == cnt0) n_pend[i] = b;
                    end
                    n_cnt = cnt0 + 2'd1;
                end
            end else begin
                // Broken sequence: one replacement per held byte, then restart.
                o_cmd.repl = {1'b0, cnt0};
                n_cnt      = 2'd0;
                do_fresh   = 1'b1;
            end
        end

        if (do_fresh) begin
            case (b)
                8'h22:   esc = 8'h22;
                8'h5C:   esc = 8'h5C;
                8'h08:   esc = 8'h62;
                8'h0C:   esc = 8'h66;
                8'h0A:   esc = 8'h6E;
                8'h0D:   esc = 8'h72;
                8'h09:   esc = 8'h74;
                default: esc = 8'h00;
            endcase
            if (esc != 8'h00) begin
                o_cmd.kind     = jse_pkg::K_ESC;
                o_cmd.bytes[0] = esc;
            end else if (b < 8'h20) begin
                o_cmd.kind     = jse_pkg::K_HEX;
                o_cmd.bytes[0] = b;
            end else if (b < 8'h80) begin
                o_cmd.kind     = jse_pkg::K_LIT;
                o_cmd.nbytes   = 2'd0;
                o_cmd.bytes[0] = b;
            end else if (seq_len(b) != 3'd0) begin
                n_pend[0] = b;
                n_cnt     = 2'd1;
            end else begin
                o_cmd.repl = o_cmd.repl + 3'd1;
            end
        end

        // End of string: flush held bytes as replacements.
        if (i_item.last_of_string) begin
            o_cmd.repl = o_cmd.repl + {1'b0, n_cnt};
            n_cnt      = 2'd0;
        end

        o_push = i_accept && (o_cmd.open || o_cmd.repl != 3'd0 ||
                              o_cmd.kind != jse_pkg::K_NONE || o_cmd.close);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

`default_nettype wire

/* design/jse_fifo.sv */
// Two-entry command queue between classifier and emitter.
`timescale 1ns / 1ps
`default_nettype none

module jse_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  jse_pkg::t_cmd     i_cmd,
    input  wire logic         i_pop,
    output jse_pkg::t_cmd     o_head,
    output jse_pkg::t_qstat   o_stat
);

    jse_pkg::t_cmd r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/jse_back.sv */
// Emitter: expands the head command into output bytes, one per cycle while the receiver does not stall.
`timescale 1ns / 1ps
`default_nettype none

module jse_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  jse_pkg::t_cmd     i_head,
    input  jse_pkg::t_qstat   i_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_stall,
    output jse_pkg::t_out     o_data
);

    logic          r_busy;
    logic [1:0]    r_phase;
    logic [2:0]    r_sub;
    logic [2:0]    r_rcnt;
    logic          r_out_valid;
    jse_pkg::t_out r_out;

    logic          w_load;
    logic          w_done;
    logic [1:0]    w_phase;
    logic [2:0]    w_sub;
    logic [2:0]    w_rcnt;
    logic [1:0]    n_phase;
    logic [2:0]    n_sub;
    logic [2:0]    n_rcnt;
    jse_pkg::t_out w_out;

    // First phase at or after 'from' that the command uses; bit 2 = found.
    function automatic logic [2:0] seek(input jse_pkg::t_cmd c, input logic [1:0] from);
        logic [2:0] r;
        if (from <= jse_pkg::P_OPEN && c.open) r = {1'b1, jse_pkg::P_OPEN};
        else if (from <= jse_pkg::P_REPL && c.repl != 3'd0) r = {1'b1, jse_pkg::P_REPL};
        else if (from <= jse_pkg::P_BODY && c.kind != jse_pkg::K_NONE)
            r = {1'b1, jse_pkg::P_BODY};
        else if (c.close) r = {1'b1, jse_pkg::P_CLOSE};
        else r = {1'b0, jse_pkg::P_CLOSE};
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction

    function automatic logic [7:0] repl_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = jse_pkg::C_BSLASH;
            3'd1:    c = 8'h75;
            3'd2:    c = 8'h46;
            3'd3:    c = 8'h46;
            3'd4:    c = 8'h46;
            default: c = 8'h44;
        endcase
        return c;
    endfunction

    always_comb begin
        logic       pend_end;
        logic [2:0] nxt;
        logic [2:0] start;

        start    = seek(i_head, jse_pkg::P_OPEN);
        w_phase  = r_busy ? r_phase : start[1:0];
        w_sub    = r_busy ? r_sub : 3'd0;
        w_rcnt   = r_busy ? r_rcnt : 3'd0;
        w_out    = '0;
        pend_end = 1'b1;
        nxt      = 3'd0;
        n_phase  = w_phase;
        n_sub    = w_sub + 3'd1;
        n_rcnt   = w_rcnt;

        case (w_phase)
            jse_pkg::P_OPEN: begin
                w_out.out_byte = jse_pkg::C_QUOTE;
            end
            jse_pkg::P_REPL: begin
                w_out.out_byte = repl_char(w_sub);
                if (w_sub == 3'd5) begin
                    n_sub  = 3'd0;
                    n_rcnt = w_rcnt + 3'd1;
                end
                pend_end = (w_sub == 3'd5) && (w_rcnt + 3'd1 == i_head.repl);
            end
            jse_pkg::P_BODY: begin
                case (i_head.kind)
                    jse_pkg::K_LIT: begin
                        w_out.out_byte = i_head.bytes[w_sub[1:0]];
                        pend_end       = (w_sub == {1'b0, i_head.nbytes});
                    end
                    jse_pkg::K_ESC: begin
                        w_out.out_byte = (w_sub == 3'd0) ? jse_pkg::C_BSLASH
                                                         : i_head.bytes[0];
                        pend_end       = (w_sub == 3'd1);
                    end
                    jse_pkg::K_HEX: begin
                        case (w_sub)
                            3'd0:    w_out.out_byte = jse_pkg::C_BSLASH;
                            3'd1:    w_out.out_byte = 8'h75;
                            3'd2:    w_out.out_byte = 8'h30;
                            3'd3:    w_out.out_byte = 8'h30;
                            3'd4:    w_out.out_byte = hex_char(i_head.bytes[0][7:4]);
                            default: w_out.out_byte = hex_char(i_head.bytes[0][3:0]);
                        endcase
                        pend_end = (w_sub == 3'd5);
                    end
                    default: begin
                        w_out.out_byte = 8'h00;
                    end
                endcase
            end
            default: begin
                w_out.out_byte      = jse_pkg::C_QUOTE;
                w_out.closing_quote = 1'b1;
            end
        endcase

        w_done = 1'b0;
        if (pend_end) begin
            n_sub  = 3'd0;
            n_rcnt = 3'd0;
            if (w_phase == jse_pkg::P_CLOSE) begin
                w_done = 1'b1;
            end else begin
                nxt     = seek(i_head, w_phase + 2'd1);
                n_phase = nxt[1:0];
                w_done  = !nxt[2];
            end
        end
        w_out.last_of_run = w_done;

        w_load = !i_stat.empty && (!r_out_valid || !i_stall);
        o_pop  = w_load && w_done;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= jse_pkg::P_OPEN;
            r_sub       <= 3'd0;
            r_rcnt      <= 3'd0;
        end else begin
            if (w_load) begin
                r_busy      <= !w_done;
                r_phase     <= n_phase;
                r_sub       <= n_sub;
                r_rcnt      <= n_rcnt;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_out <= w_out;
        end
    end

endmodule

`default_nettype wire

/* design/json_string_escape_utf8.sv */
// Top level of the JSON string escaper with UTF-8 checking.
//
// Input channel (i_valid / o_stall / i_data): one transaction per string
// byte, flagged first, last or empty. Output channel (o_valid / i_stall /
// o_data): one transaction per byte of the quoted, escaped JSON literal;
// last_of_run marks the final byte caused by an input transaction and
// closing_quote marks the closing quote.
// The command enters the queue at the accepting edge; the emitter then loads
// the first output byte from the queue head into the output register, which
// presents it to the receiver.
// The emitter sends one byte per cycle while the receiver does not stall. An
// input transaction produces 1 byte for a plain character, 2 for a short
// escape, 6 for \u00XX or \uFFFD, up to 25 with the closing quote and
// flushed replacements. Bytes held in a pending UTF-8 sequence produce
// nothing and occupy neither the queue nor the emitter. The emitter's
// one-byte-per-cycle output register sets the rate of the escaper.
// Reset (synchronous, active low) empties the queue, drops the output
// register and forgets any pending sequence.
// When the receiver stalls, the output register holds its byte; the
// two-entry command queue fills and then o_stall rises to hold the sender.
`timescale 1ns / 1ps
`default_nettype none

module json_string_escape_utf8 (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  jse_pkg::t_in      i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output jse_pkg::t_out     o_data
);

    logic            w_accept;
    logic            w_push;
    logic            w_pop;
    jse_pkg::t_cmd   w_cmd;
    jse_pkg::t_cmd   w_head;
    jse_pkg::t_qstat w_stat;

    // Stall only on a full queue; the classifier itself never waits.
    assign o_stall  = w_stat.full;
    assign w_accept = i_valid && !w_stat.full;

    // Classify the transaction and update the pending sequence.
    jse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_data),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    // Hold commands so front and back stall independently.
    jse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // Expand commands into output bytes.
    jse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

/* design/jse_checker.sv */
// Port-level checks of the JSON string escaper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jse_checker (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_valid,
    input wire logic     o_stall,
    input jse_pkg::t_in  i_data,
    input wire logic     o_valid,
    input wire logic     i_stall,
    input jse_pkg::t_out o_data
);

    // A stalled input transaction holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("input changed while stalled");

    // A stalled output transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");

    // The closing quote ends its run and is a quote character.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.closing_quote |->
            o_data.last_of_run && o_data.out_byte == jse_pkg::C_QUOTE)
        else $error("bad closing quote");

    // Escaping never emits a NUL byte.
    a_no_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.out_byte != 8'h00)
        else $error("NUL byte on output");

    // Nothing comes out right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind json_string_escape_utf8 jse_checker u_jse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
